>>> src/rdsc_pkg.sv
`default_nettype none

package rdsc_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int MAX_RADIX   = 16;
   localparam int ALPHA_SLOTS = 16;
   localparam int RADIX_CAP   = (MAX_RADIX < ALPHA_SLOTS) ? MAX_RADIX : ALPHA_SLOTS;
   localparam int RADIX_W     = 5;
   localparam int DIGIT_W     = $clog2(ALPHA_SLOTS);
   localparam int CHAR_W      = 8;

   localparam int STORE_DEPTH = 64;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

   // The divider retires this many quotient bits per cycle.
   localparam int STEP_BITS = 8;
   localparam int STEPS     = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
   localparam int QUOT_W    = STEPS * STEP_BITS;
   localparam int BCNT_W    = (STEPS > 1) ? $clog2(STEPS) : 1;

   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_BAD_ALPHABET = 2'd1,
      STATUS_BAD_RADIX    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_ALPHABET_LOW  = 2'd0,
      CSR_ALPHABET_HIGH = 2'd1,
      CSR_BASE_LENGTH   = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_EMIT_RD,
      ST_EMIT_PUT
   } state_type;

   typedef enum logic [1:0] {
      OUT_ERR_RADIX,
      OUT_ERR_ALPHABET,
      OUT_ZERO,
      OUT_DIGIT
   } out_sel_type;

   typedef struct packed {
      logic        load;
      logic        div_step;
      logic        set_ptr;
      logic        dec_ptr;
      logic        push;
      out_sel_type sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic radix_low;
      logic alpha_bad;
      logic value_zero;
      logic step_last;
      logic digit_final;
      logic ptr_zero;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

>>> src/radix_digit_string_converter.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_number_in
// rsp_      out        rsp_valid/rsp_stall  rsp_digit_char, rsp_last_digit, rsp_convert_status
// csr_      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// An item that ends in an error or is zero is answered from the check state. Otherwise
// the divider works out each digit in turn (8 quotient bits per cycle through one
// compare-subtract chain), and emission reads each digit back (registered digit
// store read) and puts it out once the output is free.
// Reset is synchronous and clears control state and the configuration.
// The next item is accepted while the final result still waits in rsp_.

module radix_digit_string_converter
   import rdsc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [VALUE_WIDTH-1:0] req_number_in,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [CHAR_W-1:0]           rsp_digit_char,
   output logic                        rsp_last_digit,
   output logic [1:0]                  rsp_convert_status,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [1:0]             csr_index,
   input  wire logic [63:0]            csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   rdsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rdsc_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_number_in      (req_number_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digit_char     (rsp_digit_char),
      .rsp_last_digit     (rsp_last_digit),
      .rsp_convert_status (rsp_convert_status)
   );

   // An error result is always a lone, empty item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_convert_status != STATUS_OK |-> rsp_digit_char == '0 && rsp_last_digit)
      else $error("error result carries a character or is not marked last");

   // Once an item is taken the block is busy with it.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted again right after an item");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_convert_status == STATUS_OK ||
                    rsp_convert_status == STATUS_BAD_ALPHABET ||
                    rsp_convert_status == STATUS_BAD_RADIX)
      else $error("undefined status code on result");

endmodule

`default_nettype wire

>>> src/rdsc_ctrl.sv
`default_nettype none

module rdsc_ctrl
   import rdsc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.sel   = OUT_DIGIT;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // The radix check takes precedence over the alphabet check.
            if (status.radix_low || status.alpha_bad || status.value_zero) begin
               if (status.out_free) begin
                  cmd.push = 1'b1;
                  if (status.radix_low) begin
                     cmd.sel = OUT_ERR_RADIX;
                  end else if (status.alpha_bad) begin
                     cmd.sel = OUT_ERR_ALPHABET;
                  end else begin
                     cmd.sel = OUT_ZERO;
                  end
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.step_last && status.digit_final) begin
               cmd.set_ptr = 1'b1;
               state_in    = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_PUT;
         end
         ST_EMIT_PUT: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               cmd.sel  = OUT_DIGIT;
               if (status.ptr_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.dec_ptr = 1'b1;
                  state_in    = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> src/rdsc_dp.sv
`default_nettype none

module rdsc_dp
   import rdsc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ctrl_cmd_type           cmd,
   output dp_status_type               status,
   input  wire logic                   csr_write,
   input  wire logic [1:0]             csr_index,
   input  wire logic [63:0]            csr_wdata,
   input  wire logic [VALUE_WIDTH-1:0] req_number_in,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [CHAR_W-1:0]           rsp_digit_char,
   output logic                        rsp_last_digit,
   output logic [1:0]                  rsp_convert_status
);

   logic [63:0]        alpha_low_ff;
   logic [63:0]        alpha_high_ff;
   logic [RADIX_W-1:0] base_len_ff;

   logic [ALPHA_SLOTS*CHAR_W-1:0] alpha_vec;
   logic [RADIX_W-1:0]            radix;
   logic                          alpha_bad;

   logic [QUOT_W-1:0]   quot_ff;
   logic [QUOT_W-1:0]   quot_in;
   logic [DIGIT_W-1:0]  rem_ff;
   logic [DIGIT_W-1:0]  rem_v;
   logic [STEP_BITS-1:0] qbyte;
   logic [BCNT_W-1:0]   bcnt_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [STORE_AW-1:0] ptr_ff;
   logic                step_last;

   logic [DIGIT_W-1:0] digit_mem [STORE_DEPTH];
   logic [DIGIT_W-1:0] rd_data_ff;

   logic              rsp_valid_ff;
   logic [CHAR_W-1:0] rsp_char_ff;
   logic              rsp_last_ff;
   status_type        rsp_status_ff;
   logic              out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_low_ff  <= '0;
         alpha_high_ff <= '0;
         base_len_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ALPHABET_LOW:  alpha_low_ff  <= csr_wdata;
            CSR_ALPHABET_HIGH: alpha_high_ff <= csr_wdata;
            CSR_BASE_LENGTH:   base_len_ff   <= csr_wdata[RADIX_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign alpha_vec = {alpha_high_ff, alpha_low_ff};
   assign radix     = (base_len_ff > RADIX_W'(RADIX_CAP)) ? RADIX_W'(RADIX_CAP) : base_len_ff;

   // Only the characters in use take part: no sign character, no duplicate.
   always_comb begin
      alpha_bad = 1'b0;
      for (int i = 0; i < ALPHA_SLOTS; i++) begin
         if (RADIX_W'(i) < radix) begin
            if (alpha_vec[i*CHAR_W +: CHAR_W] == CHAR_PLUS ||
                alpha_vec[i*CHAR_W +: CHAR_W] == CHAR_MINUS) begin
               alpha_bad = 1'b1;
            end
            for (int j = i + 1; j < ALPHA_SLOTS; j++) begin
               if (RADIX_W'(j) < radix &&
                   alpha_vec[j*CHAR_W +: CHAR_W] == alpha_vec[i*CHAR_W +: CHAR_W]) begin
                  alpha_bad = 1'b1;
               end
            end
         end
      end
   end

   // Restoring division by the radix, one top byte of the quotient per cycle.
   // The byte of quotient bits shifts in at the bottom, so after the last step of a
   // digit the register holds the full quotient again.
   always_comb begin
      logic [DIGIT_W:0]     t;
      logic [STEP_BITS-1:0] top;
      top   = quot_ff[QUOT_W-1 -: STEP_BITS];
      rem_v = rem_ff;
      qbyte = '0;
      t     = '0;
      for (int k = STEP_BITS - 1; k >= 0; k--) begin
         t = {rem_v, top[k]};
         if (t >= (DIGIT_W+1)'(radix)) begin
            qbyte[k] = 1'b1;
            rem_v    = DIGIT_W'(t - (DIGIT_W+1)'(radix));
         end else begin
            rem_v = t[DIGIT_W-1:0];
         end
      end
      quot_in = QUOT_W'({quot_ff, qbyte});
   end

   assign step_last = (bcnt_ff == BCNT_W'(STEPS - 1));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         quot_ff <= QUOT_W'(req_number_in);
         rem_ff  <= '0;
      end else if (cmd.div_step) begin
         quot_ff <= quot_in;
         rem_ff  <= step_last ? '0 : rem_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bcnt_ff <= '0;
         cnt_ff  <= '0;
         ptr_ff  <= '0;
      end else begin
         if (cmd.load) begin
            bcnt_ff <= '0;
            cnt_ff  <= '0;
         end else if (cmd.div_step) begin
            bcnt_ff <= step_last ? '0 : bcnt_ff + 1'b1;
            if (step_last) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         if (cmd.set_ptr) begin
            ptr_ff <= cnt_ff[STORE_AW-1:0];
         end else if (cmd.dec_ptr) begin
            ptr_ff <= ptr_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_step && step_last) begin
         digit_mem[cnt_ff[STORE_AW-1:0]] <= rem_v;
      end
      rd_data_ff <= digit_mem[ptr_ff];
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         case (cmd.sel)
            OUT_ERR_RADIX: begin
               rsp_char_ff   <= '0;
               rsp_last_ff   <= 1'b1;
               rsp_status_ff <= STATUS_BAD_RADIX;
            end
            OUT_ERR_ALPHABET: begin
               rsp_char_ff   <= '0;
               rsp_last_ff   <= 1'b1;
               rsp_status_ff <= STATUS_BAD_ALPHABET;
            end
            OUT_ZERO: begin
               rsp_char_ff   <= CHAR_ZERO;
               rsp_last_ff   <= 1'b1;
               rsp_status_ff <= STATUS_OK;
            end
            OUT_DIGIT: begin
               rsp_char_ff   <= alpha_vec[{rd_data_ff, 3'b000} +: CHAR_W];
               rsp_last_ff   <= (ptr_ff == '0);
               rsp_status_ff <= STATUS_OK;
            end
            default: begin
               rsp_char_ff   <= '0;
               rsp_last_ff   <= 1'b1;
               rsp_status_ff <= STATUS_BAD_RADIX;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_digit_char     = rsp_char_ff;
   assign rsp_last_digit     = rsp_last_ff;
   assign rsp_convert_status = rsp_status_ff;

   assign status.radix_low   = (radix < RADIX_W'(2));
   assign status.alpha_bad   = alpha_bad;
   assign status.value_zero  = (quot_ff == '0);
   assign status.step_last   = step_last;
   assign status.digit_final = (quot_in == '0) || (cnt_ff == CNT_W'(STORE_DEPTH - 1));
   assign status.ptr_zero    = (ptr_ff == '0);
   assign status.out_free    = out_free;

endmodule

`default_nettype wire

>>> bench/rdsc_digit_checker.sv
module rdsc_digit_checker
   import rdsc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [VALUE_WIDTH-1:0] req_number_in,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [CHAR_W-1:0]      rsp_digit_char,
   input  logic                   rsp_last_digit,
   input  logic [1:0]             rsp_convert_status,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [63:0]            csr_wdata,
   output int                     mismatch_count,
   output int                     pending_digits,
   output int                     numbers_seen,
   output int                     digits_seen,
   output int                     error_replies
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              final_digit;
      status_type        status;
   } digit_reply_type;

   digit_reply_type expected_digits[$];

   // Shadow of the configuration, slot d of the alphabet in byte d.
   logic [ALPHA_SLOTS*CHAR_W-1:0] alphabet = '0;
   logic [RADIX_W-1:0]            base_length = '0;

   int mismatches = 0;
   int numbers    = 0;
   int replies    = 0;
   int errors     = 0;

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      mismatches++;
      $display("[%0t] rdsc checker: %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   function automatic logic [CHAR_W-1:0] glyph(input int d);
      return alphabet[d*CHAR_W +: CHAR_W];
   endfunction

   function automatic bit alphabet_clean(input int radix);
      int i;
      int j;
      logic [CHAR_W-1:0] c;
      for (i = 0; i < radix; i++) begin
         c = glyph(i);
         if (c == CHAR_PLUS || c == CHAR_MINUS) return 1'b0;
         for (j = i + 1; j < radix; j++) begin
            if (glyph(j) == c) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic void push_reply(input logic [CHAR_W-1:0] ch, input logic final_digit,
                                      input status_type status);
      digit_reply_type e;
      e.ch          = ch;
      e.final_digit = final_digit;
      e.status      = status;
      expected_digits.push_back(e);
   endfunction

   function automatic void predict_number(input logic [VALUE_WIDTH-1:0] value);
      int radix;
      int n;
      int k;
      logic [VALUE_WIDTH-1:0] q;
      logic [VALUE_WIDTH-1:0] divisor;
      logic [DIGIT_W-1:0]     rem [STORE_DEPTH];
      radix = (int'(base_length) > RADIX_CAP) ? RADIX_CAP : int'(base_length);
      numbers++;
      // Radix is checked before the alphabet, and both before the zero case.
      if (radix < 2) begin
         push_reply('0, 1'b1, STATUS_BAD_RADIX);
      end else if (!alphabet_clean(radix)) begin
         push_reply('0, 1'b1, STATUS_BAD_ALPHABET);
      end else if (value == '0) begin
         push_reply(CHAR_ZERO, 1'b1, STATUS_OK);
      end else begin
         divisor = VALUE_WIDTH'(radix);
         q = value;
         n = 0;
         while (q != '0 && n < STORE_DEPTH) begin
            rem[n] = DIGIT_W'(q % divisor);
            q = q / divisor;
            n++;
         end
         for (k = n - 1; k >= 0; k--) begin
            push_reply(glyph(int'(rem[k])), k == 0, STATUS_OK);
         end
      end
   endfunction

   task automatic check_reply();
      digit_reply_type want;
      replies++;
      if (expected_digits.size() == 0) begin
         report("result with no number pending", rsp_digit_char, '0);
         return;
      end
      want = expected_digits.pop_front();
      if (want.status != STATUS_OK) errors++;
      if (rsp_digit_char !== want.ch) report("digit_char", rsp_digit_char, want.ch);
      if (rsp_last_digit !== want.final_digit) begin
         report("last_digit", rsp_last_digit, want.final_digit);
      end
      if (rsp_convert_status !== want.status) begin
         report("convert_status", rsp_convert_status, want.status);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_digits.delete();
         alphabet    = '0;
         base_length = '0;
      end else begin
         if (rsp_valid && !rsp_stall) check_reply();
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ALPHABET_LOW:  alphabet[63:0]   = csr_wdata;
               CSR_ALPHABET_HIGH: alphabet[127:64] = csr_wdata;
               CSR_BASE_LENGTH:   base_length      = csr_wdata[RADIX_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_number(req_number_in);
      end
      mismatch_count <= mismatches;
      pending_digits <= expected_digits.size();
      numbers_seen   <= numbers;
      digits_seen    <= replies;
      error_replies  <= errors;
   end

endmodule

>>> bench/tb_radix_digit_string_converter.sv
module tb_radix_digit_string_converter
   import rdsc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 5_000_000;
   localparam int HOLD_CYCLES   = 600;
   localparam int DRAIN_CYCLES  = 700;
   localparam int RANDOM_PHASES = 18;
   localparam int PHASE_ITEMS   = 20;
   localparam int HOLD_PHASE    = 5;

   // Index past the end of the register list; the block must ignore it.
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   // "0123456789abcdef", digit value 0 in the low byte.
   localparam logic [127:0] HEX_ALPHABET = {64'h6665_6463_6261_3938, 64'h3736_3534_3332_3130};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [VALUE_WIDTH-1:0] req_number_in = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [CHAR_W-1:0]      rsp_digit_char;
   logic                   rsp_last_digit;
   logic [1:0]             rsp_convert_status;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [1:0]             csr_index = '0;
   logic [63:0]            csr_wdata = '0;

   int mismatch_count;
   int pending_digits;
   int numbers_seen;
   int digits_seen;
   int error_replies;

   int cycle_count   = 0;
   int settings_used = 0;
   bit rx_busy       = 1'b0;
   bit hold_pending  = 1'b0;

   always #6 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   radix_digit_string_converter dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_number_in      (req_number_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digit_char     (rsp_digit_char),
      .rsp_last_digit     (rsp_last_digit),
      .rsp_convert_status (rsp_convert_status),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   rdsc_digit_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_number_in      (req_number_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digit_char     (rsp_digit_char),
      .rsp_last_digit     (rsp_last_digit),
      .rsp_convert_status (rsp_convert_status),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .mismatch_count     (mismatch_count),
      .pending_digits     (pending_digits),
      .numbers_seen       (numbers_seen),
      .digits_seen        (digits_seen),
      .error_replies      (error_replies)
   );

   function automatic int sender_gap(input bit busy);
      int r;
      r = $urandom_range(0, 99);
      if (!busy || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] pick_number();
      logic [VALUE_WIDTH-1:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return '1;
         2:       return VALUE_WIDTH'(1) << $urandom_range(0, VALUE_WIDTH - 1);
         default: return v >> $urandom_range(0, VALUE_WIDTH - 1);
      endcase
   endfunction

   // Sixteen distinct characters free of signs. A corrupted alphabet gets a sign or a
   // repeat inside the radix; a clean one sometimes carries one beyond it.
   function automatic logic [127:0] random_alphabet(input int radix, input bit corrupt);
      logic [127:0]      a;
      bit [255:0]        used;
      logic [CHAR_W-1:0] c;
      int                slot;
      int                other;
      used = '0;
      used[CHAR_PLUS]  = 1'b1;
      used[CHAR_MINUS] = 1'b1;
      for (slot = 0; slot < ALPHA_SLOTS; slot++) begin
         do c = CHAR_W'($urandom_range(0, 255)); while (used[c]);
         used[c] = 1'b1;
         a[slot*CHAR_W +: CHAR_W] = c;
      end
      if (radix < 2) return a;
      if (corrupt) begin
         slot = $urandom_range(0, radix - 1);
         other = (slot + 1 + $urandom_range(0, radix - 2)) % radix;
      end else if (radix < ALPHA_SLOTS && $urandom_range(0, 2) == 0) begin
         slot = $urandom_range(radix, ALPHA_SLOTS - 1);
         other = $urandom_range(0, ALPHA_SLOTS - 1);
      end else begin
         return a;
      end
      case ($urandom_range(0, 2))
         0:       a[slot*CHAR_W +: CHAR_W] = CHAR_PLUS;
         1:       a[slot*CHAR_W +: CHAR_W] = CHAR_MINUS;
         default: if (other != slot) a[slot*CHAR_W +: CHAR_W] = a[other*CHAR_W +: CHAR_W];
      endcase
      return a;
   endfunction

   task automatic send_number(input logic [VALUE_WIDTH-1:0] value, input int gap);
      req_valid     <= 1'b1;
      req_number_in <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (pending_digits != 0) @(posedge clock);
   endtask

   task automatic configure(input logic [127:0] alphabet, input logic [63:0] base_word,
                            input bit poke_unused);
      logic [1:0]  which [4];
      logic [63:0] data  [4];
      int          count;
      int          k;
      which[0] = CSR_ALPHABET_LOW;
      data[0]  = alphabet[63:0];
      which[1] = CSR_ALPHABET_HIGH;
      data[1]  = alphabet[127:64];
      count = 2;
      if (poke_unused) begin
         which[count] = CSR_UNUSED;
         data[count]  = {$urandom, $urandom};
         count++;
      end
      which[count] = CSR_BASE_LENGTH;
      data[count]  = base_word;
      count++;
      wait_idle();
      for (k = 0; k < count; k++) begin
         csr_valid <= 1'b1;
         csr_index <= which[k];
         csr_wdata <= data[k];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Output side: random stalls, plus one long hold-off on request.
   initial begin : receiver_side
      int run;
      int r;
      bit level;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            level = 1'b0;
            run   = 1;
            if (rx_busy) begin
               r = $urandom_range(0, 99);
               if (r < 65) begin
                  run = $urandom_range(1, 3);
               end else if (r < 93) begin
                  level = 1'b1;
                  run   = $urandom_range(1, 3);
               end else begin
                  level = 1'b1;
                  run   = $urandom_range(10, 40);
               end
            end
            rsp_stall <= level;
            repeat (run - 1) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb_radix_digit_string_converter: FAIL");
      $finish;
   end

   initial begin : stimulus
      logic [127:0] alpha;
      logic [63:0]  base_word;
      int           p;
      int           i;
      int           code;
      int           r;
      bit           tx_busy;
      bit           corrupt;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset leaves the radix at zero.
      @(posedge clock);
      send_number(64'd5, 1);

      configure(HEX_ALPHABET, 64'd1, 1'b0);
      send_number('0, 1);

      configure(HEX_ALPHABET, 64'd16, 1'b1);
      send_number('0, 0);
      send_number(64'd1, 0);
      send_number('1, 0);
      send_number(64'h8000_0000_0000_0000, 0);
      send_number(64'h0123_4567_89AB_CDEF, 0);
      send_number(64'd15, 1);

      // Binary gives the longest digit strings.
      configure(HEX_ALPHABET, 64'd2, 1'b0);
      send_number('1, 0);
      send_number(64'h8000_0000_0000_0000, 0);
      send_number(64'd2, 1);

      // Radix beyond the alphabet saturates.
      configure(HEX_ALPHABET, 64'd31, 1'b0);
      send_number(64'hDEAD_BEEF_0BAD_F00D, 1);

      configure(HEX_ALPHABET, 64'd10, 1'b0);
      send_number('1, 1);

      alpha = HEX_ALPHABET;
      alpha[3*CHAR_W +: CHAR_W] = CHAR_PLUS;
      configure(alpha, 64'd16, 1'b0);
      send_number('0, 0);
      send_number(64'd77, 1);

      alpha = HEX_ALPHABET;
      alpha[15*CHAR_W +: CHAR_W] = CHAR_MINUS;
      configure(alpha, 64'd16, 1'b0);
      send_number(64'd1, 1);

      // The same sign just outside the radix is harmless.
      configure(alpha, 64'd15, 1'b0);
      send_number(64'd255, 1);

      alpha = HEX_ALPHABET;
      alpha[9*CHAR_W +: CHAR_W] = alpha[0 +: CHAR_W];
      configure(alpha, 64'd10, 1'b0);
      send_number(64'd42, 1);

      // A zero byte is an ordinary digit, yet a zero input still prints '0'.
      alpha = HEX_ALPHABET;
      alpha[0 +: CHAR_W]      = 8'h00;
      alpha[CHAR_W +: CHAR_W] = 8'hFF;
      configure(alpha, 64'd3, 1'b0);
      send_number('0, 0);
      send_number(64'd9, 1);

      for (p = 0; p < RANDOM_PHASES; p++) begin
         r = $urandom_range(0, 99);
         if (r < 10)      code = 2;
         else if (r < 20) code = 16;
         else if (r < 27) code = $urandom_range(17, 31);
         else if (r < 32) code = $urandom_range(0, 1);
         else             code = $urandom_range(3, 15);
         corrupt = ($urandom_range(0, 4) == 0);
         alpha = random_alphabet((code > RADIX_CAP) ? RADIX_CAP : code, corrupt);
         base_word = {$urandom, $urandom};
         base_word[RADIX_W-1:0] = RADIX_W'(code);
         configure(alpha, base_word, $urandom_range(0, 3) == 0);

         tx_busy = ($urandom_range(0, 2) != 0);
         rx_busy = ($urandom_range(0, 2) != 0);
         if (p == HOLD_PHASE) begin
            // Keep offering items back to back while the output is held off.
            tx_busy = 1'b0;
            hold_pending = 1'b1;
         end
         for (i = 0; i < PHASE_ITEMS; i++) begin
            send_number(pick_number(),
                        (i == PHASE_ITEMS - 1) ? $urandom_range(1, 4) : sender_gap(tx_busy));
         end
      end

      wait_idle();
      rx_busy = 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d numbers under %0d register settings, radix 0 to 31 and bad alphabets.",
               numbers_seen, settings_used);
      $display("Checked %0d results, %0d of them error replies, with a %0d-cycle output hold-off.",
               digits_seen, error_replies, HOLD_CYCLES);
      if (mismatch_count == 0 && pending_digits == 0) begin
         $display("tb_radix_digit_string_converter: PASS");
      end else begin
         $display("tb_radix_digit_string_converter: FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/rdsc_pkg.sv
src/rdsc_ctrl.sv
src/rdsc_dp.sv
src/radix_digit_string_converter.sv
bench/rdsc_digit_checker.sv
bench/tb_radix_digit_string_converter.sv
